// ----- rtl/core/rj_pkg.sv -----
// Shared types and constants of the radar measurement Jacobian pipeline.
package rj_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int LANES       = 6;
   localparam int SQRT_STAGES = 32;
   localparam int QUO_W       = 33;
   localparam int DIV_STAGES  = QUO_W;
   localparam int NUM_W       = 128;
   localparam int DEN_W       = 96;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] range_dx;
      logic signed [31:0] range_dy;
      logic signed [31:0] bearing_dx;
      logic signed [31:0] bearing_dy;
      logic signed [31:0] rate_dx;
      logic signed [31:0] rate_dy;
      logic               zero_range;
      logic               saturated;
   } rsp_type;

   // Values that ride along with the square root pipeline.
   typedef struct packed {
      logic [31:0] mx;
      logic [31:0] my;
      logic        nx;
      logic        ny;
      logic        nc;
      logic [63:0] cm;
      logic [63:0] a;
   } side_type;

   // Per-lane result signs and the origin flag, carried beside the dividers.
   typedef struct packed {
      logic [LANES-1:0] neg;
      logic             zero;
   } fin_type;

endpackage

// ----- rtl/core/radar_jacobian_top.sv -----
// Top level of the radar measurement Jacobian pipeline.
//
// Takes one track state (pos_x, pos_y, vel_x, vel_y, signed Q15.16) per
// cycle and returns the distinct entries of the range / bearing / range-rate
// Jacobian, each truncated toward zero and saturated to 32 bits, with a
// zero_range flag for a track at the origin and a saturated flag when any
// entry was clipped. Sustained rate is one transaction per cycle. A result
// passes three front stages, 32 square root stages, two product stages,
// 33 divider stages and the output queue, as the square root and dividers
// give one bit per stage. The whole pipeline advances together while the
// two-entry output queue has room, so one finished result can wait there
// without stopping intake; once both entries are full the pipeline holds
// until the result channel takes one.
module radar_jacobian_top import rj_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic [31:0]        mx;
      logic [31:0]        my;
      logic               nx;
      logic               ny;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
   } s1_type;

   typedef struct packed {
      logic [63:0]        sqx;
      logic [63:0]        sqy;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
      logic [31:0]        mx;
      logic [31:0]        my;
      logic               nx;
      logic               ny;
   } s2_type;

   typedef struct packed {
      logic [63:0] als;
      logic [63:0] ahs;
      logic [63:0] xl;
      logic [63:0] xh;
      logic [63:0] yl;
      logic [63:0] yh;
      logic [31:0] root;
      side_type    side;
   } s4_type;

   typedef struct packed {
      logic [LANES-1:0][NUM_W-1:0] num;
      logic [LANES-1:0][DEN_W-1:0] den;
      fin_type                     fin;
   } s5_type;

   logic adv;

   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   side_type s3_ff, s3_in;
   s4_type   s4_ff, s4_in;
   s5_type   s5_ff, s5_in;
   logic     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   logic     sq_valid;
   logic [31:0] sq_root;
   side_type sq_side;

   logic [QUO_W-1:0] quo [LANES];

   fin_type fin_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] vd_ff;

   rsp_type fin_rsp;
   logic    push;

   // Whole pipeline moves as one while the output queue can take a result.
   assign req_ready = adv;

   // Stage 1: register the transaction with position magnitudes and signs.
   always_comb begin
      s1_in.px = req_data.pos_x;
      s1_in.py = req_data.pos_y;
      s1_in.vx = req_data.vel_x;
      s1_in.vy = req_data.vel_y;
      s1_in.nx = req_data.pos_x[31];
      s1_in.ny = req_data.pos_y[31];
      s1_in.mx = req_data.pos_x[31] ? 32'(-req_data.pos_x) : req_data.pos_x;
      s1_in.my = req_data.pos_y[31] ? 32'(-req_data.pos_y) : req_data.pos_y;
   end

   // Stage 2: squares of the position and the two halves of the cross term.
   always_comb begin
      s2_in.sqx = s1_ff.mx * s1_ff.mx;
      s2_in.sqy = s1_ff.my * s1_ff.my;
      s2_in.p1  = s1_ff.vx * s1_ff.py;
      s2_in.p2  = s1_ff.vy * s1_ff.px;
      s2_in.mx  = s1_ff.mx;
      s2_in.my  = s1_ff.my;
      s2_in.nx  = s1_ff.nx;
      s2_in.ny  = s1_ff.ny;
   end

   // Stage 3: range squared and the cross term as sign plus magnitude.
   always_comb begin
      logic signed [64:0] dif;
      dif = {s2_ff.p1[63], s2_ff.p1} - {s2_ff.p2[63], s2_ff.p2};
      s3_in.a  = s2_ff.sqx + s2_ff.sqy;
      s3_in.nc = dif[64];
      s3_in.cm = dif[64] ? 64'(-dif) : dif[63:0];
      s3_in.mx = s2_ff.mx;
      s3_in.my = s2_ff.my;
      s3_in.nx = s2_ff.nx;
      s3_in.ny = s2_ff.ny;
   end

   rj_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .in_side   (s3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Stage 4: 32x32 partial products of range^3 and of the rate numerators.
   always_comb begin
      s4_in.als  = sq_side.a[31:0] * sq_root;
      s4_in.ahs  = sq_side.a[63:32] * sq_root;
      s4_in.xl   = sq_side.mx * sq_side.cm[31:0];
      s4_in.xh   = sq_side.mx * sq_side.cm[63:32];
      s4_in.yl   = sq_side.my * sq_side.cm[31:0];
      s4_in.yh   = sq_side.my * sq_side.cm[63:32];
      s4_in.root = sq_root;
      s4_in.side = sq_side;
   end

   // Stage 5: assemble numerators, divisors and result signs per lane.
   always_comb begin
      logic [DEN_W-1:0] d3;
      logic [DEN_W-1:0] nx3;
      logic [DEN_W-1:0] ny3;
      logic mxnz;
      logic mynz;
      logic cmnz;
      d3   = {s4_ff.ahs, 32'b0} + DEN_W'(s4_ff.als);
      nx3  = {s4_ff.xh, 32'b0} + DEN_W'(s4_ff.xl);
      ny3  = {s4_ff.yh, 32'b0} + DEN_W'(s4_ff.yl);
      mxnz = (s4_ff.side.mx != '0);
      mynz = (s4_ff.side.my != '0);
      cmnz = (s4_ff.side.cm != '0);

      s5_in.num[0] = NUM_W'(s4_ff.side.mx) << FRAC_BITS;
      s5_in.den[0] = DEN_W'(s4_ff.root);
      s5_in.num[1] = NUM_W'(s4_ff.side.my) << FRAC_BITS;
      s5_in.den[1] = DEN_W'(s4_ff.root);
      s5_in.num[2] = NUM_W'(s4_ff.side.my) << (2 * FRAC_BITS);
      s5_in.den[2] = DEN_W'(s4_ff.side.a);
      s5_in.num[3] = NUM_W'(s4_ff.side.mx) << (2 * FRAC_BITS);
      s5_in.den[3] = DEN_W'(s4_ff.side.a);
      s5_in.num[4] = NUM_W'(ny3) << FRAC_BITS;
      s5_in.den[4] = d3;
      s5_in.num[5] = NUM_W'(nx3) << FRAC_BITS;
      s5_in.den[5] = d3;

      s5_in.fin.neg[0] = s4_ff.side.nx;
      s5_in.fin.neg[1] = s4_ff.side.ny;
      s5_in.fin.neg[2] = !s4_ff.side.ny && mynz;
      s5_in.fin.neg[3] = s4_ff.side.nx;
      s5_in.fin.neg[4] = (s4_ff.side.ny ^ s4_ff.side.nc) && mynz && cmnz;
      s5_in.fin.neg[5] = !(s4_ff.side.nx ^ s4_ff.side.nc) && mxnz && cmnz;
      s5_in.fin.zero   = (s4_ff.side.a == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vd_ff <= '0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= sq_valid;
         v5_ff <= v4_ff;
         vd_ff <= {vd_ff[DIV_STAGES-2:0], v5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         fin_ff[0] <= s5_ff.fin;
         for (int k = 1; k < DIV_STAGES; k++) begin
            fin_ff[k] <= fin_ff[k-1];
         end
      end
   end

   // One divider lane per Jacobian entry.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      rj_div_pipe u_div (
         .clock   (clock),
         .adv     (adv),
         .in_num  (s5_ff.num[l]),
         .in_den  (s5_ff.den[l]),
         .out_quo (quo[l])
      );
   end

   // Finish: clip each magnitude to its signed limit, apply the sign, and
   // force all entries to zero for a track at the origin.
   always_comb begin
      logic [QUO_W-1:0] limit;
      logic [31:0]      mag;
      logic [31:0]      val [LANES];
      logic             clip;
      logic             sat;
      fin_type          f;
      f   = fin_ff[DIV_STAGES-1];
      sat = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         limit = {1'b0, f.neg[l], {31{!f.neg[l]}}};
         clip  = (quo[l] > limit);
         mag   = clip ? limit[31:0] : quo[l][31:0];
         val[l] = f.neg[l] ? 32'(-mag) : mag;
         sat   = sat | clip;
      end
      if (f.zero) begin
         fin_rsp = '0;
         fin_rsp.zero_range = 1'b1;
      end else begin
         fin_rsp.range_dx   = val[0];
         fin_rsp.range_dy   = val[1];
         fin_rsp.bearing_dx = val[2];
         fin_rsp.bearing_dy = val[3];
         fin_rsp.rate_dx    = val[4];
         fin_rsp.rate_dy    = val[5];
         fin_rsp.zero_range = 1'b0;
         fin_rsp.saturated  = sat;
      end
   end

   // Drop finished transactions into the output queue as they leave.
   assign push = adv && vd_ff[DIV_STAGES-1];

   rj_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (fin_rsp),
      .space     (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/rj_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage.
module rj_sqrt_pipe import rj_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  side_type in_side,
   output logic     out_valid,
   output logic [31:0] out_root,
   output side_type out_side
);

   logic [63:0] rem_ff  [SQRT_STAGES];
   logic [63:0] rem_in  [SQRT_STAGES];
   logic [63:0] res_ff  [SQRT_STAGES];
   logic [63:0] res_in  [SQRT_STAGES];
   side_type    side_ff [SQRT_STAGES];
   side_type    side_in [SQRT_STAGES];
   logic [SQRT_STAGES-1:0] valid_ff;
   logic [SQRT_STAGES-1:0] valid_in;

   always_comb begin
      logic [63:0] r;
      logic [63:0] q;
      logic [63:0] b;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            r = in_side.a;
            q = '0;
            side_in[k]  = in_side;
            valid_in[k] = in_valid;
         end else begin
            r = rem_ff[k-1];
            q = res_ff[k-1];
            side_in[k]  = side_ff[k-1];
            valid_in[k] = valid_ff[k-1];
         end
         b = 64'(1) << (62 - 2 * k);
         if (r >= q + b) begin
            rem_in[k] = r - (q + b);
            res_in[k] = (q >> 1) + b;
         end else begin
            rem_in[k] = r;
            res_in[k] = q >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            res_ff[k]  <= res_in[k];
            side_ff[k] <= side_in[k];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = res_ff[SQRT_STAGES-1][31:0];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

// ----- rtl/core/rj_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage; top bit flags overflow.
module rj_div_pipe import rj_pkg::*; (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   output logic [QUO_W-1:0] out_quo
);

   logic [NUM_W-1:0] rem_ff [DIV_STAGES];
   logic [NUM_W-1:0] rem_in [DIV_STAGES];
   logic [DEN_W-1:0] den_ff [DIV_STAGES];
   logic [DEN_W-1:0] den_in [DIV_STAGES];
   logic [QUO_W-1:0] quo_ff [DIV_STAGES];
   logic [QUO_W-1:0] quo_in [DIV_STAGES];

   always_comb begin
      logic [NUM_W-1:0] r;
      logic [NUM_W-1:0] t;
      logic [DEN_W-1:0] d;
      logic [QUO_W-1:0] q;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            r = in_num;
            d = in_den;
            q = '0;
         end else begin
            r = rem_ff[k-1];
            d = den_ff[k-1];
            q = quo_ff[k-1];
         end
         t = NUM_W'(d) << (QUO_W - 1 - k);
         den_in[k] = d;
         if (r >= t) begin
            rem_in[k] = r - t;
            quo_in[k] = {q[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = r;
            quo_in[k] = {q[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_quo = quo_ff[DIV_STAGES-1];

endmodule

// ----- rtl/core/rj_out_buf.sv -----
// Two-entry output queue that decouples the pipeline from the result channel.
module rj_out_buf import rj_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type    slot_ff [2];
   logic       head_ff;
   logic       head_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       tail;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[head_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign tail      = head_ff ^ count_ff[0];

   always_comb begin
      head_in  = pop ? !head_ff : head_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail] <= push_data;
      end
   end

endmodule

// ----- rtl/core/rj_checker.sv -----
// Port-level checks of the Jacobian pipeline and their binding to the top level.
module rj_checker import rj_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A waiting result holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // A track at the origin gives all-zero entries and no clipping.
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_range |->
         !rsp_data.saturated && rsp_data.range_dx == 0 && rsp_data.range_dy == 0 &&
         rsp_data.bearing_dx == 0 && rsp_data.bearing_dy == 0 &&
         rsp_data.rate_dx == 0 && rsp_data.rate_dy == 0)
      else $error("origin result not cleared");

   // Reset empties the output queue.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind radar_jacobian_top rj_checker u_checker (.*);
